// ===== hdl/ssfp_pkg.sv =====
// Shared types and constants for the servo status frame parser.
// No dependencies; used by ssfp_core and servo_status_frame_parser.
package ssfp_pkg;

    localparam int IN_TDATA_W  = 40;
    localparam int OUT_TDATA_W = 32;
    localparam int OUT_TUSER_W = 2;

    // Receive phases
    localparam logic [2:0] PH_ID     = 3'd0;
    localparam logic [2:0] PH_LENGTH = 3'd1;
    localparam logic [2:0] PH_STATUS = 3'd2;
    localparam logic [2:0] PH_DATA   = 3'd3;
    localparam logic [2:0] PH_CHECK  = 3'd4;

    // Item kinds on the input tuser bit
    localparam logic OP_ARM  = 1'b0;
    localparam logic OP_BYTE = 1'b1;

    localparam logic [7:0] SYNC_BYTE    = 8'hFF;
    localparam logic [7:0] LEN_OVERHEAD = 8'd2;

    typedef logic [2:0] t_phase;

    typedef struct packed {
        logic       op;
        logic [7:0] rx_byte;
        logic [7:0] arm_id;
        logic [7:0] arm_length;
        logic       arm_is_read;
        logic [7:0] arm_addr;
    } t_item;

    typedef struct packed {
        logic       store_valid;
        logic [7:0] store_addr;
        logic [7:0] store_data;
        logic       frame_done;
        logic       frame_good;
        logic [7:0] servo_status;
    } t_result;

endpackage

// ===== hdl/ssfp_core.sv =====
// Frame receive state machine: steps one item per cycle while i_step is high and builds the result.
// Depends on ssfp_pkg.
module ssfp_core (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_step,
    input  ssfp_pkg::t_item  i_item,
    output logic             o_res_valid,
    output ssfp_pkg::t_result o_res
);

    ssfp_pkg::t_phase r_phase, n_phase;
    logic [7:0] r_exp_id, n_exp_id;
    logic [7:0] r_exp_len, n_exp_len;
    logic       r_read, n_read;
    logic [7:0] r_base, n_base;
    logic [7:0] r_count, n_count;
    logic [7:0] r_sum, n_sum;
    logic [7:0] r_status, n_status;

    logic [7:0] ch;
    logic [7:0] cnt_inc;

    assign ch      = i_item.rx_byte;
    assign cnt_inc = r_count + 8'd1;

    always_comb begin
        n_phase     = r_phase;
        n_exp_id    = r_exp_id;
        n_exp_len   = r_exp_len;
        n_read      = r_read;
        n_base      = r_base;
        n_count     = r_count;
        n_sum       = r_sum;
        n_status    = r_status;
        o_res_valid = 1'b0;
        o_res       = '0;
        if (i_item.op == ssfp_pkg::OP_ARM) begin
            n_exp_id  = i_item.arm_id;
            n_exp_len = i_item.arm_length;
            n_read    = i_item.arm_is_read;
            n_base    = i_item.arm_addr;
            n_phase   = ssfp_pkg::PH_ID;
            n_count   = '0;
            n_sum     = '0;
        end else begin
            unique case (r_phase)
                ssfp_pkg::PH_LENGTH: begin
                    if (ch != r_exp_len) begin
                        n_phase = ssfp_pkg::PH_ID;
                    end else begin
                        n_sum   = r_sum + ch;
                        n_phase = ssfp_pkg::PH_STATUS;
                    end
                end
                ssfp_pkg::PH_STATUS: begin
                    n_status = ch;
                    n_sum    = r_sum + ch;
                    n_count  = '0;
                    n_phase  = (r_exp_len > ssfp_pkg::LEN_OVERHEAD) ?
                               ssfp_pkg::PH_DATA : ssfp_pkg::PH_CHECK;
                end
                ssfp_pkg::PH_DATA: begin
                    n_sum = r_sum + ch;
                    if (r_read) begin
                        o_res_valid      = 1'b1;
                        o_res.store_valid = 1'b1;
                        o_res.store_addr = r_base + r_count;
                        o_res.store_data = ch;
                    end
                    // advance to checksum after the last data byte
                    if (cnt_inc >= r_exp_len - ssfp_pkg::LEN_OVERHEAD) begin
                        n_count = '0;
                        n_phase = ssfp_pkg::PH_CHECK;
                    end else begin
                        n_count = cnt_inc;
                    end
                end
                ssfp_pkg::PH_CHECK: begin
                    n_phase            = ssfp_pkg::PH_ID;
                    o_res_valid        = 1'b1;
                    o_res.frame_done   = 1'b1;
                    o_res.frame_good   = (ch == ~r_sum);
                    o_res.servo_status = r_status;
                end
                default: begin
                    // hunt for the id; sync bytes never match
                    if (ch != ssfp_pkg::SYNC_BYTE && ch == r_exp_id) begin
                        n_sum   = ch;
                        n_phase = ssfp_pkg::PH_LENGTH;
                    end else begin
                        n_phase = ssfp_pkg::PH_ID;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= ssfp_pkg::PH_ID;
            r_exp_id  <= '0;
            r_exp_len <= ssfp_pkg::LEN_OVERHEAD;
            r_read    <= 1'b0;
            r_base    <= '0;
            r_count   <= '0;
            r_sum     <= '0;
            r_status  <= '0;
        end else if (i_step) begin
            r_phase   <= n_phase;
            r_exp_id  <= n_exp_id;
            r_exp_len <= n_exp_len;
            r_read    <= n_read;
            r_base    <= n_base;
            r_count   <= n_count;
            r_sum     <= n_sum;
            r_status  <= n_status;
        end
    end

endmodule

// ===== hdl/servo_status_frame_parser.sv =====
// Servo status frame parser: items are registered at input, results at output.
// One item per cycle unless the sink stalls; ssfp_core's per-byte update sets it.
// Every item waits in the input register until the output register is free or its
// result leaves; a new item is taken in the same cycle the result leaves.
// Synchronous active-low reset clears the frame state and both valid flags.
// Depends on ssfp_pkg and ssfp_core.
module servo_status_frame_parser (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_s_axis_tvalid,
    output logic                              o_s_axis_tready,
    // rx_byte, arm_id, arm_length, arm_is_read, arm_addr, zero fill
    input  logic [ssfp_pkg::IN_TDATA_W-1:0]   i_s_axis_tdata,
    // op
    input  logic                              i_s_axis_tuser,
    output logic                              o_m_axis_tvalid,
    input  logic                              i_m_axis_tready,
    // store_addr, store_data, frame_good, servo_status, zero fill
    output logic [ssfp_pkg::OUT_TDATA_W-1:0]  o_m_axis_tdata,
    // store_valid, frame_done
    output logic [ssfp_pkg::OUT_TUSER_W-1:0]  o_m_axis_tuser
);

    logic              r_in_valid;
    ssfp_pkg::t_item   r_in_item;
    ssfp_pkg::t_item   in_item;
    logic              r_out_valid;
    ssfp_pkg::t_result r_out;
    ssfp_pkg::t_result res;
    logic              res_valid;
    logic              accept;
    logic              advance;

    assign in_item.op          = i_s_axis_tuser;
    assign in_item.rx_byte     = i_s_axis_tdata[7:0];
    assign in_item.arm_id      = i_s_axis_tdata[15:8];
    assign in_item.arm_length  = i_s_axis_tdata[23:16];
    assign in_item.arm_is_read = i_s_axis_tdata[24];
    assign in_item.arm_addr    = i_s_axis_tdata[32:25];

    assign advance         = r_in_valid && (!r_out_valid || i_m_axis_tready);
    assign o_s_axis_tready = !r_in_valid || !r_out_valid || i_m_axis_tready;
    assign accept          = i_s_axis_tvalid && o_s_axis_tready;

    ssfp_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_step      (advance),
        .i_item      (r_in_item),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else begin
            r_in_valid <= accept || (r_in_valid && !advance);
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_in_item <= in_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance && res_valid) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    // hold the result while the sink stalls
    always_ff @(posedge i_clk) begin
        if (advance && res_valid) begin
            r_out <= res;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {7'd0, r_out.servo_status, r_out.frame_good,
                              r_out.store_data, r_out.store_addr};
    assign o_m_axis_tuser  = {r_out.frame_done, r_out.store_valid};

`ifndef SYNTH
    a_one_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> $onehot(o_m_axis_tuser))
        else $error("result is neither a single store nor a single done");

    a_store_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && o_m_axis_tuser[0]) |-> (o_m_axis_tdata[24:16] == 9'd0))
        else $error("store result carries frame status bits");

    a_done_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && o_m_axis_tuser[1]) |-> (o_m_axis_tdata[15:0] == 16'd0))
        else $error("done result carries store address or data");

    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !advance) |=> (r_in_valid && $stable(r_in_item)))
        else $error("pending item lost while output stalled");
`endif

endmodule
